// File: sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Field widths and operation codes shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int KIND_W = 4;
   localparam int NUM_W  = 33;
   localparam int DEN_W  = 31;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_ADD = 4'd0;
   localparam logic [KIND_W-1:0] KIND_SUB = 4'd1;
   localparam logic [KIND_W-1:0] KIND_MUL = 4'd2;
   localparam logic [KIND_W-1:0] KIND_DIV = 4'd3;
   localparam logic [KIND_W-1:0] KIND_EQ  = 4'd4;
   localparam logic [KIND_W-1:0] KIND_NE  = 4'd5;
   localparam logic [KIND_W-1:0] KIND_LT  = 4'd6;
   localparam logic [KIND_W-1:0] KIND_GT  = 4'd7;
   localparam logic [KIND_W-1:0] KIND_LE  = 4'd8;
   localparam logic [KIND_W-1:0] KIND_GE  = 4'd9;

endpackage

// File: sv/rau_if.sv
// ----------------------------------------------------------------------------
// rau_if
// Valid/ready channels of the rational arithmetic unit: operand word in,
// result word out.
// ----------------------------------------------------------------------------
interface rau_req_if #(parameter int W = 16);
   logic                          valid;
   logic                          ready;
   logic [rau_pkg::KIND_W-1:0]    kind;
   logic signed [W-1:0]           a_num;
   logic signed [W-1:0]           a_den;
   logic signed [W-1:0]           b_num;
   logic signed [W-1:0]           b_den;

   modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [rau_pkg::NUM_W-1:0] res_num;
   logic [rau_pkg::DEN_W-1:0]     res_den;
   logic                          truth;
   logic                          error;

   modport source (output valid, res_num, res_den, truth, error, input ready);
   modport sink   (input valid, res_num, res_den, truth, error, output ready);
endinterface

// File: sv/rau_mul.sv
// ----------------------------------------------------------------------------
// rau_mul
// Shared unsigned magnitude multiplier, product registered.
// ----------------------------------------------------------------------------
module rau_mul #(
   parameter int W = 16
) (
   input  logic           clock,
   input  logic [W-1:0]   op_a,
   input  logic [W-1:0]   op_b,
   output logic [2*W-1:0] prod
);

   logic [2*W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= (2*W)'(op_a) * (2*W)'(op_b);
   end

   assign prod = prod_ff;

endmodule

// File: sv/rau_red.sv
// ----------------------------------------------------------------------------
// rau_red
// Reduces x/y to lowest terms on one subtractor: binary gcd, then two
// restoring divisions by the odd part of the gcd.
// ----------------------------------------------------------------------------
module rau_red #(
   parameter int PW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [PW-1:0] x_in,
   input  logic [PW-1:0] y_in,
   output logic          done,
   output logic [PW-1:0] qx,
   output logic [PW-1:0] qy
);

   localparam int CW = $clog2(PW);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GCD  = 3'd1;
   localparam logic [2:0] S_DIVX = 3'd2;
   localparam logic [2:0] S_DIVY = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [PW-1:0] x_ff, x_in_nx;
   logic [PW-1:0] y_ff, y_in_nx;
   logic [PW-1:0] qx_ff, qx_in;
   logic [PW-1:0] qy_ff, qy_in;
   logic [PW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [PW:0]   sa, sb;
   logic [PW+1:0] diff;
   logic          borrow;
   logic          last;

   // the one subtractor
   always_comb begin
      unique case (state_ff)
         S_DIVX: begin
            sa = {rem_ff, qx_ff[PW-1]};
            sb = {1'b0, x_ff};
         end
         S_DIVY: begin
            sa = {rem_ff, qy_ff[PW-1]};
            sb = {1'b0, x_ff};
         end
         default: begin
            sa = {1'b0, x_ff};
            sb = {1'b0, y_ff};
         end
      endcase
   end

   assign diff   = {1'b0, sa} - {1'b0, sb};
   assign borrow = diff[PW+1];
   assign last   = (cnt_ff == CW'(PW-1));

   always_comb begin
      state_in = state_ff;
      x_in_nx  = x_ff;
      y_in_nx  = y_ff;
      qx_in    = qx_ff;
      qy_in    = qy_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               x_in_nx  = x_in;
               y_in_nx  = y_in;
               qx_in    = x_in;
               qy_in    = y_in;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (diff == '0) begin
               // x holds the odd part of the gcd
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIVX;
            end else if (!x_ff[0] && !y_ff[0]) begin
               // common factor two leaves the originals too
               x_in_nx = x_ff >> 1;
               y_in_nx = y_ff >> 1;
               qx_in   = qx_ff >> 1;
               qy_in   = qy_ff >> 1;
            end else if (!x_ff[0]) begin
               x_in_nx = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in_nx = y_ff >> 1;
            end else if (borrow) begin
               x_in_nx = y_ff;
               y_in_nx = x_ff;
            end else begin
               x_in_nx = {1'b0, diff[PW-1:1]};
            end
         end
         S_DIVX: begin
            rem_in = borrow ? sa[PW-1:0] : diff[PW-1:0];
            qx_in  = {qx_ff[PW-2:0], ~borrow};
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIVY;
            end
         end
         S_DIVY: begin
            rem_in = borrow ? sa[PW-1:0] : diff[PW-1:0];
            qy_in  = {qy_ff[PW-2:0], ~borrow};
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in_nx;
      y_ff   <= y_in_nx;
      qx_ff  <= qx_in;
      qy_ff  <= qy_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done = (state_ff == S_DONE);
   assign qx   = qx_ff;
   assign qy   = qy_ff;

endmodule

// File: sv/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit - fraction add/sub/mul/div and compare, gcd reduced
// Compares, errors and zero results pass MUL0..MUL3, SIGN, EVAL, DECIDE and
// FIN; reduced results add a binary gcd pass and two restoring divisions,
// all on the single subtractor in rau_red; one word in flight, ready only
// while idle.
// Reset (synchronous): sequencer idle, no result valid; datapath not reset.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic   clock,
   input  logic   reset,
   rau_req_if.sink   req,
   rau_rsp_if.source rsp
);

   localparam int W   = OPERAND_WIDTH;
   localparam int PW  = 2 * W;                 // product magnitude width
   localparam int SW  = PW + 2;                // signed sum width
   localparam int NW  = rau_pkg::NUM_W;
   localparam int DW  = rau_pkg::DEN_W;
   localparam int EW  = (PW > NW) ? PW : NW;   // numerator wrap width
   localparam int DEW = (PW > DW) ? PW : DW;   // denominator wrap width

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MUL0   = 4'd1;
   localparam logic [3:0] S_MUL1   = 4'd2;
   localparam logic [3:0] S_MUL2   = 4'd3;
   localparam logic [3:0] S_MUL3   = 4'd4;
   localparam logic [3:0] S_SIGN   = 4'd5;
   localparam logic [3:0] S_EVAL   = 4'd6;
   localparam logic [3:0] S_DECIDE = 4'd7;
   localparam logic [3:0] S_RED    = 4'd8;
   localparam logic [3:0] S_FIN    = 4'd9;

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
      mag_of = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   // ---- state ------------------------------------------------------------
   logic [3:0]                 state_ff, state_in;
   logic [rau_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [W-1:0]               an_ff, an_in, ad_ff, ad_in;
   logic [W-1:0]               bn_ff, bn_in, bd_ff, bd_in;
   logic                       an_neg_ff, an_neg_in, bn_neg_ff, bn_neg_in;
   logic                       err_ff, err_in;
   logic [PW-1:0]              p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic signed [SW-1:0]       v0_ff, v0_in, v1_ff, v1_in, sum_ff, sum_in;
   logic                       lt_ff, lt_in, eq_ff, eq_in;
   logic                       neg_ff, neg_in;
   logic [NW-1:0]              fin_num_ff, fin_num_in;
   logic [DW-1:0]              fin_den_ff, fin_den_in;
   logic                       fin_truth_ff, fin_truth_in;
   logic                       fin_err_ff, fin_err_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]              rsp_num_ff, rsp_num_in;
   logic [DW-1:0]              rsp_den_ff, rsp_den_in;
   logic                       rsp_truth_ff, rsp_truth_in;
   logic                       rsp_err_ff, rsp_err_in;

   // ---- datapath wires ---------------------------------------------------
   logic [W-1:0]         mul_a, mul_b;
   logic [PW-1:0]        mul_p;
   logic                 red_start, red_done;
   logic [PW-1:0]        red_x, red_qx, red_qy;
   logic                 muldiv, neg0, neg1;
   logic signed [SW-1:0] e0, e1, abs_sum;
   logic [EW-1:0]        qx_ext, qx_signed;
   logic [DEW-1:0]       qy_ext;
   logic                 cmp_truth;
   logic                 accept;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);

   // one multiplier serves all three products: numerator-side, cross, den
   always_comb begin
      unique case (state_ff)
         S_MUL0: begin
            mul_a = an_ff;
            mul_b = (kind_ff == rau_pkg::KIND_MUL) ? bn_ff : bd_ff;
         end
         S_MUL1: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         S_MUL2: begin
            mul_a = ad_ff;
            mul_b = (kind_ff == rau_pkg::KIND_DIV) ? bn_ff : bd_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   rau_mul #(.W(W)) u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   // signs: den signs already folded into numerator signs at accept;
   // mul/div carry the product sign on p0 and leave the cross term out
   assign muldiv = (kind_ff == rau_pkg::KIND_MUL) || (kind_ff == rau_pkg::KIND_DIV);
   assign neg0   = muldiv ? (an_neg_ff ^ bn_neg_ff) : an_neg_ff;
   assign neg1   = bn_neg_ff ^ (kind_ff == rau_pkg::KIND_SUB);
   assign e0     = signed'(SW'(p0_ff));
   assign e1     = signed'(SW'(p1_ff));

   assign abs_sum = sum_ff[SW-1] ? -sum_ff : sum_ff;
   assign red_x   = abs_sum[PW-1:0];

   // comparison decode on the cross products
   always_comb begin
      unique case (kind_ff)
         rau_pkg::KIND_EQ: cmp_truth = eq_ff;
         rau_pkg::KIND_NE: cmp_truth = !eq_ff;
         rau_pkg::KIND_LT: cmp_truth = lt_ff;
         rau_pkg::KIND_GT: cmp_truth = !lt_ff && !eq_ff;
         rau_pkg::KIND_LE: cmp_truth = lt_ff || eq_ff;
         rau_pkg::KIND_GE: cmp_truth = !lt_ff;
         default:          cmp_truth = 1'b0;
      endcase
   end

   rau_red #(.PW(PW)) u_red (
      .clock (clock),
      .reset (reset),
      .start (red_start),
      .x_in  (red_x),
      .y_in  (p2_ff),
      .done  (red_done),
      .qx    (red_qx),
      .qy    (red_qy)
   );

   // reduced result: sign back onto numerator, wrap to field widths
   assign qx_ext    = EW'(red_qx);
   assign qx_signed = neg_ff ? (~qx_ext + 1'b1) : qx_ext;
   assign qy_ext    = DEW'(red_qy);

   // ---- sequencer --------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      an_neg_in    = an_neg_ff;
      bn_neg_in    = bn_neg_ff;
      err_in       = err_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      v0_in        = v0_ff;
      v1_in        = v1_ff;
      sum_in       = sum_ff;
      lt_in        = lt_ff;
      eq_in        = eq_ff;
      neg_in       = neg_ff;
      fin_num_in   = fin_num_ff;
      fin_den_in   = fin_den_ff;
      fin_truth_in = fin_truth_ff;
      fin_err_in   = fin_err_ff;
      red_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_truth_in = rsp_truth_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in   = req.kind;
               an_in     = mag_of(req.a_num);
               ad_in     = mag_of(req.a_den);
               bn_in     = mag_of(req.b_num);
               bd_in     = mag_of(req.b_den);
               an_neg_in = (mag_of(req.a_num) != '0) && (req.a_num[W-1] ^ req.a_den[W-1]);
               bn_neg_in = (mag_of(req.b_num) != '0) && (req.b_num[W-1] ^ req.b_den[W-1]);
               err_in    = (req.a_den == '0) || (req.b_den == '0);
               state_in  = S_MUL0;
            end
         end
         S_MUL0: state_in = S_MUL1;
         S_MUL1: begin
            p0_in    = mul_p;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            p1_in    = mul_p;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            p2_in    = mul_p;
            state_in = S_SIGN;
         end
         S_SIGN: begin
            v0_in    = neg0 ? -e0 : e0;
            v1_in    = muldiv ? '0 : (neg1 ? -e1 : e1);
            state_in = S_EVAL;
         end
         S_EVAL: begin
            sum_in   = v0_ff + v1_ff;
            lt_in    = v0_ff < v1_ff;
            eq_in    = v0_ff == v1_ff;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            // default answer 0/1, no truth, no error
            fin_num_in   = '0;
            fin_den_in   = DW'(1);
            fin_truth_in = 1'b0;
            fin_err_in   = 1'b0;
            state_in     = S_FIN;
            if (err_ff) begin
               fin_err_in = 1'b1;
            end else if (kind_ff <= rau_pkg::KIND_DIV) begin
               if (kind_ff == rau_pkg::KIND_DIV && bn_ff == '0) begin
                  fin_err_in = 1'b1;           // division by a zero fraction
               end else if (sum_ff != '0) begin
                  neg_in    = sum_ff[SW-1];
                  red_start = 1'b1;
                  state_in  = S_RED;
               end
            end else begin
               fin_truth_in = cmp_truth;
            end
         end
         S_RED: begin
            if (red_done) begin
               fin_num_in = qx_signed[NW-1:0];
               fin_den_in = qy_ext[DW-1:0];
               state_in   = S_FIN;
            end
         end
         S_FIN: begin
            // output register free or being emptied this cycle
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = fin_num_ff;
               rsp_den_in   = fin_den_ff;
               rsp_truth_in = fin_truth_ff;
               rsp_err_in   = fin_err_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      an_ff        <= an_in;
      ad_ff        <= ad_in;
      bn_ff        <= bn_in;
      bd_ff        <= bd_in;
      an_neg_ff    <= an_neg_in;
      bn_neg_ff    <= bn_neg_in;
      err_ff       <= err_in;
      p0_ff        <= p0_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      v0_ff        <= v0_in;
      v1_ff        <= v1_in;
      sum_ff       <= sum_in;
      lt_ff        <= lt_in;
      eq_ff        <= eq_in;
      neg_ff       <= neg_in;
      fin_num_ff   <= fin_num_in;
      fin_den_ff   <= fin_den_in;
      fin_truth_ff <= fin_truth_in;
      fin_err_ff   <= fin_err_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_den_ff   <= rsp_den_in;
      rsp_truth_ff <= rsp_truth_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.res_num = signed'(rsp_num_ff);
   assign rsp.res_den = rsp_den_ff;
   assign rsp.truth   = rsp_truth_ff;
   assign rsp.error   = rsp_err_ff;

`ifndef SYNTHESIS
   // error words are always 0/1 with no truth
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.error |-> rsp.res_num == '0 && rsp.res_den == DW'(1) && !rsp.truth)
      else $error("error word not 0/1");

   // a true comparison carries the 0/1 fraction
   a_truth_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.truth |-> rsp.res_num == '0 && rsp.res_den == DW'(1))
      else $error("comparison word carries a fraction");

   // accept starts the sequencer, so the next cycle is busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready && state_ff == S_MUL0)
      else $error("sequencer did not start on accept");

   // the reducer only finishes while the sequencer waits for it
   a_red_done: assert property (@(posedge clock) disable iff (reset)
      red_done |-> state_ff == S_RED)
      else $error("reducer done outside wait state");
`endif

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rational arithmetic unit. A directed table
// walks the special cases (zero denominators, division by a zero fraction,
// zero results, unused kinds, operand extremes, all compares), then random
// operand words follow. Every accepted word is predicted or has a typed-in
// answer, and every result word is compared field by field, in order, against that answer.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          OPERAND_W    = 16;
   localparam int          RANDOM_WORDS = 800;
   localparam int          DRAIN_CYCLES = 64;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;

   localparam int KIND_W = rau_pkg::KIND_W;
   localparam int NUM_W  = rau_pkg::NUM_W;
   localparam int DEN_W  = rau_pkg::DEN_W;

   // kinds without a name in the package: the unit answers 0/1
   localparam logic [KIND_W-1:0] KIND_UNUSED_LO = rau_pkg::KIND_GE + 4'd1;
   localparam logic [KIND_W-1:0] KIND_UNUSED_HI = '1;

   typedef struct {
      logic [KIND_W-1:0]          kind;
      logic signed [OPERAND_W-1:0] a_num;
      logic signed [OPERAND_W-1:0] a_den;
      logic signed [OPERAND_W-1:0] b_num;
      logic signed [OPERAND_W-1:0] b_den;
   } operand_word_type;

   typedef struct {
      logic signed [NUM_W-1:0] res_num;
      logic [DEN_W-1:0]        res_den;
      logic                    truth;
      logic                    error;
   } result_word_type;

   // directed row: has_exp set where the answer is typed in by hand
   typedef struct {
      operand_word_type word;
      bit               has_exp;
      result_word_type  exp;
   } directed_row_type;

   typedef enum {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rau_req_if #(.W(OPERAND_W)) req_if ();
   rau_rsp_if                  rsp_if ();

   rational_arithmetic_unit #(
      .OPERAND_WIDTH(OPERAND_W)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   result_word_type pending_results [$];
   int unsigned     mismatches  = 0;
   int unsigned     cycle_count = 0;
   int unsigned     burst_left  = 0;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // ------------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------------
   localparam int DIR_ROWS = 25;

   directed_row_type dir_tab [DIR_ROWS] = '{
      // plain add, checked by the predictor
      '{'{rau_pkg::KIND_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3}, 1'b0, '{default: 0}},
      // difference of equal fractions reduces to 0/1
      '{'{rau_pkg::KIND_SUB, 16'sd3, 16'sd4, 16'sd6, 16'sd8}, 1'b1,
        '{33'sd0, 31'd1, 1'b0, 1'b0}},
      // zero numerator product
      '{'{rau_pkg::KIND_MUL, 16'sd0, 16'sd7, 16'sd5, -16'sd3}, 1'b1,
        '{33'sd0, 31'd1, 1'b0, 1'b0}},
      '{'{rau_pkg::KIND_DIV, 16'sd2, 16'sd3, -16'sd4, 16'sd9}, 1'b0, '{default: 0}},
      // zero left denominator
      '{'{rau_pkg::KIND_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1}, 1'b1,
        '{33'sd0, 31'd1, 1'b0, 1'b1}},
      // zero right denominator
      '{'{rau_pkg::KIND_MUL, 16'sd5, 16'sd7, 16'sd3, 16'sd0}, 1'b1,
        '{33'sd0, 31'd1, 1'b0, 1'b1}},
      // division by a zero fraction, both denominator signs
      '{'{rau_pkg::KIND_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5}, 1'b1,
        '{33'sd0, 31'd1, 1'b0, 1'b1}},
      '{'{rau_pkg::KIND_DIV, 16'sd3, 16'sd4, 16'sd0, -16'sd5}, 1'b1,
        '{33'sd0, 31'd1, 1'b0, 1'b1}},
      // compare with a zero denominator: truth stays low
      '{'{rau_pkg::KIND_LT, 16'sd1, 16'sd0, 16'sd2, 16'sd1}, 1'b1,
        '{33'sd0, 31'd1, 1'b0, 1'b1}},
      // most negative squared: largest numerator
      '{'{rau_pkg::KIND_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1}, 1'b1,
        '{33'sd1073741824, 31'd1, 1'b0, 1'b0}},
      // most negative over itself
      '{'{rau_pkg::KIND_MUL, 16'sh8000, 16'sh8000, 16'sd1, 16'sd1}, 1'b1,
        '{33'sd1, 31'd1, 1'b0, 1'b0}},
      '{'{rau_pkg::KIND_ADD, 16'sh7FFF, 16'sd1, 16'sh7FFF, 16'sd1}, 1'b1,
        '{33'sd65534, 31'd1, 1'b0, 1'b0}},
      '{'{rau_pkg::KIND_SUB, 16'sh8000, 16'sd1, 16'sh7FFF, 16'sd1}, 1'b1,
        '{-33'sd65535, 31'd1, 1'b0, 1'b0}},
      // divisor with negative denominator, sign lands on the numerator
      '{'{rau_pkg::KIND_DIV, 16'sd1, 16'sh7FFF, 16'sd1, 16'sh8000}, 1'b1,
        '{-33'sd32768, 31'd32767, 1'b0, 1'b0}},
      // largest denominator
      '{'{rau_pkg::KIND_MUL, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000}, 1'b1,
        '{33'sd1073676289, 31'd1073741824, 1'b0, 1'b0}},
      '{'{rau_pkg::KIND_ADD, 16'sd1, 16'sh8000, 16'sd1, -16'sd32767}, 1'b0,
        '{default: 0}},
      '{'{rau_pkg::KIND_EQ, 16'sd1, 16'sd2, 16'sd2, 16'sd4}, 1'b1,
        '{33'sd0, 31'd1, 1'b1, 1'b0}},
      '{'{rau_pkg::KIND_NE, 16'sd1, 16'sd2, 16'sd2, 16'sd4}, 1'b1,
        '{33'sd0, 31'd1, 1'b0, 1'b0}},
      // -1/2 < -1/3
      '{'{rau_pkg::KIND_LT, 16'sd1, -16'sd2, -16'sd1, 16'sd3}, 1'b1,
        '{33'sd0, 31'd1, 1'b1, 1'b0}},
      '{'{rau_pkg::KIND_GT, -16'sd1, 16'sd2, 16'sd1, 16'sd3}, 1'b1,
        '{33'sd0, 31'd1, 1'b0, 1'b0}},
      '{'{rau_pkg::KIND_LE, 16'sd2, 16'sd4, 16'sd1, 16'sd2}, 1'b1,
        '{33'sd0, 31'd1, 1'b1, 1'b0}},
      '{'{rau_pkg::KIND_GE, 16'sh8000, 16'sd1, 16'sh7FFF, 16'sd1}, 1'b1,
        '{33'sd0, 31'd1, 1'b0, 1'b0}},
      // unused kinds: all-ones operands, and a zero denominator
      '{'{KIND_UNUSED_HI, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b1,
        '{33'sd0, 31'd1, 1'b0, 1'b0}},
      '{'{KIND_UNUSED_LO, 16'sd1, 16'sd1, 16'sd1, 16'sd0}, 1'b1,
        '{33'sd0, 31'd1, 1'b0, 1'b1}},
      '{'{rau_pkg::KIND_DIV, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b1,
        '{33'sd1, 31'd1, 1'b0, 1'b0}}
   };

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic longint euclid_gcd(input longint x, input longint y);
      longint t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic result_word_type rational_result(input operand_word_type w);
      result_word_type r;
      longint an, ad, bn, bd, num, den, g, lhs, rhs;
      r.res_num = '0;
      r.res_den = 31'd1;
      r.truth   = 1'b0;
      r.error   = 1'b0;
      an = w.a_num;
      ad = w.a_den;
      bn = w.b_num;
      bd = w.b_den;
      if (ad == 0 || bd == 0) begin
         r.error = 1'b1;
         return r;
      end
      // denominators positive, sign carried by the numerators
      if (ad < 0) begin
         an = -an;
         ad = -ad;
      end
      if (bd < 0) begin
         bn = -bn;
         bd = -bd;
      end
      num = 0;
      den = 1;
      lhs = an * bd;
      rhs = bn * ad;
      case (w.kind)
         rau_pkg::KIND_ADD: begin
            num = lhs + rhs;
            den = ad * bd;
         end
         rau_pkg::KIND_SUB: begin
            num = lhs - rhs;
            den = ad * bd;
         end
         rau_pkg::KIND_MUL: begin
            num = an * bn;
            den = ad * bd;
         end
         rau_pkg::KIND_DIV: begin
            if (bn == 0) begin
               r.error = 1'b1;
            end else begin
               num = an * bd;
               den = ad * bn;
               if (den < 0) begin
                  num = -num;
                  den = -den;
               end
            end
         end
         rau_pkg::KIND_EQ: r.truth = (lhs == rhs);
         rau_pkg::KIND_NE: r.truth = (lhs != rhs);
         rau_pkg::KIND_LT: r.truth = (lhs <  rhs);
         rau_pkg::KIND_GT: r.truth = (lhs >  rhs);
         rau_pkg::KIND_LE: r.truth = (lhs <= rhs);
         rau_pkg::KIND_GE: r.truth = (lhs >= rhs);
         default: ;
      endcase
      if (num != 0) begin
         g = euclid_gcd((num < 0) ? -num : num, den);
         r.res_num = NUM_W'(num / g);
         r.res_den = DEN_W'(den / g);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // sender idles in bursts: runs of back-to-back words, then a random gap
   function automatic int unsigned sender_gap();
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      // now and then a long stretch with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
      return $urandom_range(1, 12);
   endfunction

   // mix of small values (lots of common factors), full range and extremes
   function automatic logic signed [OPERAND_W-1:0] random_operand(input bit for_den);
      logic signed [OPERAND_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = OPERAND_W'($urandom_range(0, 24)) - 16'sd12;
         4, 5, 6:    v = OPERAND_W'($urandom);
         7: begin
            case ($urandom_range(0, 4))
               0:       v = 16'sh8000;
               1:       v = 16'sh7FFF;
               2:       v = -16'sd1;
               3:       v = 16'sd1;
               default: v = 16'sd0;
            endcase
         end
         default: begin
            // shared power-of-two and odd factors, gives the reduction work
            v = OPERAND_W'($urandom_range(1, 63) << $urandom_range(0, 9));
            if ($urandom_range(0, 1) == 1) v = -v;
         end
      endcase
      // keep zero denominators to a small share
      if (for_den && v == 0 && $urandom_range(0, 7) != 0) v = 16'sd1;
      return v;
   endfunction

   // one word on the request channel; expectation queued at acceptance
   task automatic send_word(input operand_word_type w, input int unsigned gap,
                            input result_word_type want);
      int unsigned k;
      if (gap != 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         for (k = 1; k < gap; k++) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.kind  <= w.kind;
      req_if.a_num <= w.a_num;
      req_if.a_den <= w.a_den;
      req_if.b_num <= w.b_num;
      req_if.b_den <= w.b_den;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_results.push_back(want);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: ready pattern in modes of random length
   // ------------------------------------------------------------------------
   rx_mode_type rx_mode      = RX_STREAM;
   int unsigned rx_mode_left = 0;

   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      <= rx_mode_type'($urandom_range(0, 3));
         rx_mode_left <= $urandom_range(50, 400);
      end else begin
         rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
         RX_STREAM:   rsp_if.ready <= 1'b1;
         RX_COIN:     rsp_if.ready <= 1'($urandom_range(0, 1));
         RX_SPARSE:   rsp_if.ready <= ($urandom_range(0, 7) == 0);
         default:     rsp_if.ready <= (rx_mode_left[2:0] != 3'd0);
      endcase
   end

   // ------------------------------------------------------------------------
   // Result checker: in-order compare against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      result_word_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result word with none pending: %0d/%0d truth %0b error %0b",
                     $time, rsp_if.res_num, rsp_if.res_den, rsp_if.truth, rsp_if.error);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.res_num !== want.res_num) begin
               $display("%0t: res_num expected %0d actual %0d",
                        $time, want.res_num, rsp_if.res_num);
               mismatches++;
            end
            if (rsp_if.res_den !== want.res_den) begin
               $display("%0t: res_den expected %0d actual %0d",
                        $time, want.res_den, rsp_if.res_den);
               mismatches++;
            end
            if (rsp_if.truth !== want.truth) begin
               $display("%0t: truth expected %0b actual %0b",
                        $time, want.truth, rsp_if.truth);
               mismatches++;
            end
            if (rsp_if.error !== want.error) begin
               $display("%0t: error expected %0b actual %0b",
                        $time, want.error, rsp_if.error);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("%0t: cycle limit reached, %0d results still pending",
               $time, pending_results.size());
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      operand_word_type w;
      result_word_type  want;
      int               i;
      req_if.valid = 1'b0;
      req_if.kind  = '0;
      req_if.a_num = '0;
      req_if.a_den = '0;
      req_if.b_num = '0;
      req_if.b_den = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (i = 0; i < DIR_ROWS; i++) begin
         if (dir_tab[i].has_exp) begin
            want = dir_tab[i].exp;
         end else begin
            want = rational_result(dir_tab[i].word);
         end
         send_word(dir_tab[i].word, sender_gap(), want);
      end

      // random words; unused kinds are rare
      for (i = 0; i < RANDOM_WORDS; i++) begin
         if ($urandom_range(0, 19) != 0)
            w.kind = KIND_W'($urandom_range(rau_pkg::KIND_ADD, rau_pkg::KIND_GE));
         else
            w.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
         w.a_num = random_operand(1'b0);
         w.a_den = random_operand(1'b1);
         w.b_num = random_operand(1'b0);
         w.b_den = random_operand(1'b1);
         send_word(w, sender_gap(), rational_result(w));
      end

      @(negedge clock);
      req_if.valid <= 1'b0;

      // drain, then watch a little longer for stray result words
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: files.f
sv/rau_pkg.sv
sv/rau_if.sv
sv/rau_mul.sv
sv/rau_red.sv
sv/rational_arithmetic_unit.sv
sim/tb_top.sv
